// ----- rtl/cbm_pkg.sv -----
// Shared types, decode constants and command format for the cartridge bank mapper.
package cbm_pkg;

    localparam int unsigned CMD_FIFO_DEPTH = 2;

    localparam logic [15:0] ADDR_MASK     = 16'hf030;
    localparam logic [15:0] ADDR_PRG0     = 16'h8000;
    localparam logic [15:0] ADDR_PRG1     = 16'h8010;
    localparam logic [15:0] ADDR_PRG2     = 16'h9000;
    localparam logic [15:0] ADDR_CHR0     = 16'ha000;
    localparam logic [15:0] ADDR_CHR1     = 16'ha010;
    localparam logic [15:0] ADDR_CHR2     = 16'hb000;
    localparam logic [15:0] ADDR_CHR3     = 16'hb010;
    localparam logic [15:0] ADDR_CHR4     = 16'hc000;
    localparam logic [15:0] ADDR_CHR5     = 16'hc010;
    localparam logic [15:0] ADDR_CHR6     = 16'hd000;
    localparam logic [15:0] ADDR_CHR7     = 16'hd010;
    localparam logic [15:0] ADDR_MIRROR   = 16'he000;
    localparam logic [15:0] ADDR_IRQ_LAT  = 16'he010;
    localparam logic [15:0] ADDR_IRQ_CTRL = 16'hf000;
    localparam logic [15:0] ADDR_IRQ_ACK  = 16'hf010;

    localparam logic [3:0]  SLOT_PRG0     = 4'd0;
    localparam logic [3:0]  SLOT_PRG1     = 4'd1;
    localparam logic [3:0]  SLOT_PRG2     = 4'd2;
    localparam logic [3:0]  SLOT_CHR0     = 4'd3;
    localparam logic [3:0]  SLOT_CHR1     = 4'd4;
    localparam logic [3:0]  SLOT_CHR2     = 4'd5;
    localparam logic [3:0]  SLOT_CHR3     = 4'd6;
    localparam logic [3:0]  SLOT_CHR4     = 4'd7;
    localparam logic [3:0]  SLOT_CHR5     = 4'd8;
    localparam logic [3:0]  SLOT_CHR6     = 4'd9;
    localparam logic [3:0]  SLOT_CHR7     = 4'd10;
    localparam logic [3:0]  SLOT_NONE     = 4'd11;

    localparam logic [1:0]  MIRROR_FLIP   = 2'h1;
    localparam logic [7:0]  LATCH_TOP     = 8'hff;
    localparam logic [8:0]  PAGE_COUNT_RESET = 9'd2;

    localparam logic        OP_WRITE      = 1'b0;
    localparam logic        OP_TICK       = 1'b1;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_PRG,
        KIND_CHR,
        KIND_MIRROR,
        KIND_LATCH,
        KIND_IRQ_CTRL,
        KIND_IRQ_ACK,
        KIND_TICK
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] slot;
        logic [7:0] data;
    } t_cmd;

endpackage

// ----- rtl/cbm_front.sv -----
// Front end: classify each incoming request into a mapper command.
module cbm_front (
    input  logic              i_push,
    input  logic              i_op,
    input  logic [15:0]       i_addr,
    input  logic [7:0]        i_data,
    input  logic              i_fifo_full,
    output logic              o_fifo_push,
    output cbm_pkg::t_cmd     o_cmd
);

    logic [15:0] masked;

    assign masked      = i_addr & cbm_pkg::ADDR_MASK;
    assign o_fifo_push = i_push && !i_fifo_full;

    always_comb begin
        o_cmd.kind = cbm_pkg::KIND_NONE;
        o_cmd.slot = cbm_pkg::SLOT_NONE;
        o_cmd.data = i_data;
        if (i_op == cbm_pkg::OP_TICK) begin
            o_cmd.kind = cbm_pkg::KIND_TICK;
        end else begin
            case (masked)
                cbm_pkg::ADDR_PRG0: begin
                    o_cmd.kind = cbm_pkg::KIND_PRG;
                    o_cmd.slot = cbm_pkg::SLOT_PRG0;
                end
                cbm_pkg::ADDR_PRG1: begin
                    o_cmd.kind = cbm_pkg::KIND_PRG;
                    o_cmd.slot = cbm_pkg::SLOT_PRG1;
                end
                cbm_pkg::ADDR_PRG2: begin
                    o_cmd.kind = cbm_pkg::KIND_PRG;
                    o_cmd.slot = cbm_pkg::SLOT_PRG2;
                end
                cbm_pkg::ADDR_CHR0: begin
                    o_cmd.kind = cbm_pkg::KIND_CHR;
                    o_cmd.slot = cbm_pkg::SLOT_CHR0;
                end
                cbm_pkg::ADDR_CHR1: begin
                    o_cmd.kind = cbm_pkg::KIND_CHR;
                    o_cmd.slot = cbm_pkg::SLOT_CHR1;
                end
                cbm_pkg::ADDR_CHR2: begin
                    o_cmd.kind = cbm_pkg::KIND_CHR;
                    o_cmd.slot = cbm_pkg::SLOT_CHR2;
                end
                cbm_pkg::ADDR_CHR3: begin
                    o_cmd.kind = cbm_pkg::KIND_CHR;
                    o_cmd.slot = cbm_pkg::SLOT_CHR3;
                end
                cbm_pkg::ADDR_CHR4: begin
                    o_cmd.kind = cbm_pkg::KIND_CHR;
                    o_cmd.slot = cbm_pkg::SLOT_CHR4;
                end
                cbm_pkg::ADDR_CHR5: begin
                    o_cmd.kind = cbm_pkg::KIND_CHR;
                    o_cmd.slot = cbm_pkg::SLOT_CHR5;
                end
                cbm_pkg::ADDR_CHR6: begin
                    o_cmd.kind = cbm_pkg::KIND_CHR;
                    o_cmd.slot = cbm_pkg::SLOT_CHR6;
                end
                cbm_pkg::ADDR_CHR7: begin
                    o_cmd.kind = cbm_pkg::KIND_CHR;
                    o_cmd.slot = cbm_pkg::SLOT_CHR7;
                end
                cbm_pkg::ADDR_MIRROR:   o_cmd.kind = cbm_pkg::KIND_MIRROR;
                cbm_pkg::ADDR_IRQ_LAT:  o_cmd.kind = cbm_pkg::KIND_LATCH;
                cbm_pkg::ADDR_IRQ_CTRL: o_cmd.kind = cbm_pkg::KIND_IRQ_CTRL;
                cbm_pkg::ADDR_IRQ_ACK:  o_cmd.kind = cbm_pkg::KIND_IRQ_ACK;
                // sound registers and unmapped space fall here: no effect
                default:                o_cmd.kind = cbm_pkg::KIND_NONE;
            endcase
        end
    end

endmodule

// ----- rtl/cbm_cmd_fifo.sv -----
// Small command queue between the front end and the execution back end.
module cbm_cmd_fifo #(
    parameter int unsigned DEPTH = cbm_pkg::CMD_FIFO_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cbm_pkg::t_cmd i_wr_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output cbm_pkg::t_cmd o_rd_cmd,
    output logic          o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    cbm_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full   = (r_count == CW'(DEPTH));
    assign o_empty  = (r_count == '0);
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && !o_empty;
    assign o_rd_cmd = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/cbm_back.sv -----
// Back end: carry out mapper commands, reduce program pages, hold the result register.
module cbm_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [8:0]    i_cfg_data,
    input  cbm_pkg::t_cmd i_cmd,
    input  logic          i_cmd_empty,
    output logic          o_cmd_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [3:0]    o_changed_slot,
    output logic [7:0]    o_slot_value,
    output logic [1:0]    o_mirror_mode,
    output logic          o_irq_pulse,
    output logic          o_irq_enabled,
    output logic [7:0]    o_irq_count
);

    typedef enum logic {S_IDLE, S_DIV} t_state;

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;
    logic [7:0] r_rem, n_rem;
    logic [7:0] r_quot, n_quot;
    logic [7:0] r_div_count, n_div_count;
    logic [3:0] r_div_slot, n_div_slot;
    logic [8:0] r_page_count, n_page_count;
    logic [1:0] r_mirror, n_mirror;
    logic [7:0] r_latch, n_latch;
    logic [7:0] r_counter, n_counter;
    logic       r_irq_en, n_irq_en;
    logic       r_irq_en_ack, n_irq_en_ack;
    logic       r_out_valid, n_out_valid;
    logic [3:0] r_out_slot, n_out_slot;
    logic [7:0] r_out_value, n_out_value;
    logic [1:0] r_out_mirror, n_out_mirror;
    logic       r_out_pulse, n_out_pulse;
    logic       r_out_irq_en, n_out_irq_en;
    logic [7:0] r_out_count, n_out_count;

    logic       out_free, cmd_take, do_load, pulse, needs_reduce;
    logic [3:0] load_slot;
    logic [7:0] load_value;
    logic [8:0] trial;

    assign out_free     = !r_out_valid || i_pop;
    assign cmd_take     = (r_state == S_IDLE) && !i_cmd_empty && out_free;
    assign o_cmd_pop    = cmd_take;
    assign needs_reduce = (r_page_count != '0) && !r_page_count[8];
    assign trial        = {r_rem, r_quot[7]};

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_rem        = r_rem;
        n_quot       = r_quot;
        n_div_count  = r_div_count;
        n_div_slot   = r_div_slot;
        n_page_count = i_cfg_valid ? i_cfg_data : r_page_count;
        n_mirror     = r_mirror;
        n_latch      = r_latch;
        n_counter    = r_counter;
        n_irq_en     = r_irq_en;
        n_irq_en_ack = r_irq_en_ack;
        n_out_valid  = r_out_valid && !i_pop;
        n_out_slot   = r_out_slot;
        n_out_value  = r_out_value;
        n_out_mirror = r_out_mirror;
        n_out_pulse  = r_out_pulse;
        n_out_irq_en = r_out_irq_en;
        n_out_count  = r_out_count;
        do_load      = 1'b0;
        pulse        = 1'b0;
        load_slot    = cbm_pkg::SLOT_NONE;
        load_value   = '0;

        case (r_state)
            S_IDLE: begin
                if (cmd_take) begin
                    do_load = 1'b1;
                    case (i_cmd.kind)
                        cbm_pkg::KIND_PRG: begin
                            if (needs_reduce) begin
                                do_load     = 1'b0;
                                n_state     = S_DIV;
                                n_step      = '0;
                                n_rem       = '0;
                                n_quot      = i_cmd.data;
                                n_div_count = r_page_count[7:0];
                                n_div_slot  = i_cmd.slot;
                            end else begin
                                load_slot  = i_cmd.slot;
                                load_value = i_cmd.data;
                            end
                        end
                        cbm_pkg::KIND_CHR: begin
                            load_slot  = i_cmd.slot;
                            load_value = i_cmd.data;
                        end
                        cbm_pkg::KIND_MIRROR: begin
                            n_mirror = i_cmd.data[1:0] ^ cbm_pkg::MIRROR_FLIP;
                        end
                        cbm_pkg::KIND_LATCH: begin
                            n_latch = cbm_pkg::LATCH_TOP - i_cmd.data;
                        end
                        cbm_pkg::KIND_IRQ_CTRL: begin
                            n_irq_en_ack = i_cmd.data[0];
                            n_irq_en     = i_cmd.data[1];
                            n_counter    = r_latch;
                        end
                        cbm_pkg::KIND_IRQ_ACK: begin
                            n_irq_en  = r_irq_en_ack;
                            n_counter = r_latch;
                        end
                        cbm_pkg::KIND_TICK: begin
                            if (r_irq_en) begin
                                if (r_counter == '0) begin
                                    pulse    = 1'b1;
                                    n_irq_en = 1'b0;
                                end else begin
                                    n_counter = r_counter - 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                // one restoring step per cycle, quotient bits discarded
                if (trial >= {1'b0, r_div_count}) begin
                    n_rem = 8'(trial - {1'b0, r_div_count});
                end else begin
                    n_rem = trial[7:0];
                end
                n_quot = {r_quot[6:0], 1'b0};
                n_step = r_step + 1'b1;
                if (r_step == 3'd7) begin
                    n_state    = S_IDLE;
                    do_load    = 1'b1;
                    load_slot  = r_div_slot;
                    load_value = n_rem;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (do_load) begin
            n_out_valid  = 1'b1;
            n_out_slot   = load_slot;
            n_out_value  = load_value;
            n_out_mirror = n_mirror;
            n_out_pulse  = pulse;
            n_out_irq_en = n_irq_en;
            n_out_count  = n_counter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= '0;
            r_page_count <= cbm_pkg::PAGE_COUNT_RESET;
            r_mirror     <= '0;
            r_latch      <= '0;
            r_counter    <= '0;
            r_irq_en     <= 1'b0;
            r_irq_en_ack <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_step       <= n_step;
            r_page_count <= n_page_count;
            r_mirror     <= n_mirror;
            r_latch      <= n_latch;
            r_counter    <= n_counter;
            r_irq_en     <= n_irq_en;
            r_irq_en_ack <= n_irq_en_ack;
            r_out_valid  <= n_out_valid;
        end
        r_rem        <= n_rem;
        r_quot       <= n_quot;
        r_div_count  <= n_div_count;
        r_div_slot   <= n_div_slot;
        r_out_slot   <= n_out_slot;
        r_out_value  <= n_out_value;
        r_out_mirror <= n_out_mirror;
        r_out_pulse  <= n_out_pulse;
        r_out_irq_en <= n_out_irq_en;
        r_out_count  <= n_out_count;
    end

    assign o_empty        = !r_out_valid;
    assign o_changed_slot = r_out_slot;
    assign o_slot_value   = r_out_value;
    assign o_mirror_mode  = r_out_mirror;
    assign o_irq_pulse    = r_out_pulse;
    assign o_irq_enabled  = r_out_irq_en;
    assign o_irq_count    = r_out_count;

    a_div_out_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !r_out_valid)
        else $error("result register occupied during page reduction");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_div_count))
        else $error("partial remainder not below page count");

    a_pulse_disables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_pulse) |-> !r_out_irq_en)
        else $error("interrupt request left the counter enabled");

    a_no_take_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !o_cmd_pop)
        else $error("command taken while reduction in progress");

endmodule

// ----- rtl/cartridge_bank_mapper_irq.sv -----
// Top level of the cartridge bank mapper with scanline interrupt counter.
// A request reaches the result ports through the command queue and the result register; a program bank
// write with a page count of 1 to 255 also passes through the serial remainder unit first.
// Throughput: one request a cycle while results are popped; none is taken while a program bank write is reduced.
// Reset (synchronous, active low) empties both queues, clears the IRQ and mirroring state
// and sets the page count to 2; no clearing pass is needed.
module cartridge_bank_mapper_irq #(
    parameter int unsigned CMD_DEPTH = cbm_pkg::CMD_FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration channel: page count
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_prg_page_count,
    // request side
    input  logic        push,
    output logic        full,
    input  logic        i_op,
    input  logic [15:0] i_addr,
    input  logic [7:0]  i_data,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_changed_slot,
    output logic [7:0]  o_slot_value,
    output logic [1:0]  o_mirror_mode,
    output logic        o_irq_pulse,
    output logic        o_irq_enabled,
    output logic [7:0]  o_irq_count
);

    cbm_pkg::t_cmd wr_cmd, rd_cmd;
    logic          fifo_push, fifo_pop, fifo_empty;

    // Register writes must arrive only while the block is idle; the block does not check; it accepts them at once.
    assign o_cfg_ready = 1'b1;

    // Decode each request into a command; the queue absorbs it while the back end is busy.
    cbm_front u_front (
        .i_push      (push),
        .i_op        (i_op),
        .i_addr      (i_addr),
        .i_data      (i_data),
        .i_fifo_full (full),
        .o_fifo_push (fifo_push),
        .o_cmd       (wr_cmd)
    );

    cbm_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (fifo_push),
        .i_wr_cmd (wr_cmd),
        .o_full   (full),
        .i_pop    (fifo_pop),
        .o_rd_cmd (rd_cmd),
        .o_empty  (fifo_empty)
    );

    // Execute commands, hold the mapper state and present one result per request.
    cbm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_prg_page_count),
        .i_cmd          (rd_cmd),
        .i_cmd_empty    (fifo_empty),
        .o_cmd_pop      (fifo_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_changed_slot (o_changed_slot),
        .o_slot_value   (o_slot_value),
        .o_mirror_mode  (o_mirror_mode),
        .o_irq_pulse    (o_irq_pulse),
        .o_irq_enabled  (o_irq_enabled),
        .o_irq_count    (o_irq_count)
    );

endmodule

// ----- dv/cartridge_bank_mapper_irq_checker.sv -----
// Result checker for the cartridge bank mapper: bank and IRQ prediction and comparison.
`timescale 1ns / 100ps

module cartridge_bank_mapper_irq_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_prg_page_count,
    input  logic        push,
    input  logic        full,
    input  logic        i_op,
    input  logic [15:0] i_addr,
    input  logic [7:0]  i_data,
    input  logic        empty,
    input  logic        pop,
    input  logic [3:0]  o_changed_slot,
    input  logic [7:0]  o_slot_value,
    input  logic [1:0]  o_mirror_mode,
    input  logic        o_irq_pulse,
    input  logic        o_irq_enabled,
    input  logic [7:0]  o_irq_count,
    output int          o_mismatches,
    output int          o_outstanding
);

    typedef struct packed {
        logic [3:0] slot;
        logic [7:0] value;
        logic [1:0] mirror;
        logic       pulse;
        logic       enabled;
        logic [7:0] count;
    } t_bank_update;

    logic [8:0] page_count;
    logic [7:0] prg_banks [0:2];
    logic [7:0] chr_banks [0:7];
    logic [1:0] mirroring;
    logic [7:0] irq_latch;
    logic [7:0] irq_counter;
    logic       irq_on;
    logic       irq_on_after_ack;

    t_bank_update pending_bank_updates[$];

    initial o_mismatches = 0;
    initial o_outstanding = 0;

    function automatic void clear_mapper();
        page_count       = cbm_pkg::PAGE_COUNT_RESET;
        prg_banks[0]     = 8'd0;
        prg_banks[1]     = 8'd1;
        prg_banks[2]     = 8'(cbm_pkg::PAGE_COUNT_RESET - 9'd2);
        for (int i = 0; i < 8; i++) chr_banks[i] = 8'd0;
        mirroring        = 2'd0;
        irq_latch        = 8'd0;
        irq_counter      = 8'd0;
        irq_on           = 1'b0;
        irq_on_after_ack = 1'b0;
    endfunction

    // Apply one request to the mapper state and return the outputs it yields.
    function automatic t_bank_update map_request(logic op, logic [15:0] addr,
                                                 logic [7:0] data);
        t_bank_update r;
        logic [3:0]   slot;
        slot    = cbm_pkg::SLOT_NONE;
        r.value = 8'd0;
        r.pulse = 1'b0;
        if (op == cbm_pkg::OP_WRITE) begin
            case (addr & cbm_pkg::ADDR_MASK)
                cbm_pkg::ADDR_PRG0: slot = cbm_pkg::SLOT_PRG0;
                cbm_pkg::ADDR_PRG1: slot = cbm_pkg::SLOT_PRG1;
                cbm_pkg::ADDR_PRG2: slot = cbm_pkg::SLOT_PRG2;
                cbm_pkg::ADDR_CHR0: slot = cbm_pkg::SLOT_CHR0;
                cbm_pkg::ADDR_CHR1: slot = cbm_pkg::SLOT_CHR1;
                cbm_pkg::ADDR_CHR2: slot = cbm_pkg::SLOT_CHR2;
                cbm_pkg::ADDR_CHR3: slot = cbm_pkg::SLOT_CHR3;
                cbm_pkg::ADDR_CHR4: slot = cbm_pkg::SLOT_CHR4;
                cbm_pkg::ADDR_CHR5: slot = cbm_pkg::SLOT_CHR5;
                cbm_pkg::ADDR_CHR6: slot = cbm_pkg::SLOT_CHR6;
                cbm_pkg::ADDR_CHR7: slot = cbm_pkg::SLOT_CHR7;
                cbm_pkg::ADDR_MIRROR: mirroring = data[1:0] ^ cbm_pkg::MIRROR_FLIP;
                cbm_pkg::ADDR_IRQ_LAT: irq_latch = cbm_pkg::LATCH_TOP - data;
                cbm_pkg::ADDR_IRQ_CTRL: begin
                    irq_on_after_ack = data[0];
                    irq_on           = data[1];
                    irq_counter      = irq_latch;
                end
                cbm_pkg::ADDR_IRQ_ACK: begin
                    irq_on      = irq_on_after_ack;
                    irq_counter = irq_latch;
                end
                default: ;
            endcase
            if (slot <= cbm_pkg::SLOT_PRG2) begin
                // zero page count stores the value unreduced
                if (page_count == 9'd0) r.value = data;
                else r.value = 8'(32'(data) % 32'(page_count));
                prg_banks[slot] = r.value;
            end else if (slot != cbm_pkg::SLOT_NONE) begin
                r.value = data;
                chr_banks[3'(slot - cbm_pkg::SLOT_CHR0)] = data;
            end
        end else if (irq_on) begin
            if (irq_counter == 8'd0) begin
                r.pulse = 1'b1;
                irq_on  = 1'b0;
            end else begin
                irq_counter = irq_counter - 8'd1;
            end
        end
        r.slot    = slot;
        r.mirror  = mirroring;
        r.enabled = irq_on;
        r.count   = irq_counter;
        return r;
    endfunction

    task automatic compare_field(string field, int want, int got);
        if (want != got) begin
            o_mismatches = o_mismatches + 1;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_bank_update want;
        if (!i_rst_n) begin
            clear_mapper();
            pending_bank_updates.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) page_count = i_cfg_prg_page_count;
            if (pop && !empty) begin
                if (pending_bank_updates.size() == 0) begin
                    o_mismatches = o_mismatches + 1;
                    $display("%0t: result with none expected, got slot %0d value %0d",
                             $time, o_changed_slot, o_slot_value);
                end else begin
                    want = pending_bank_updates.pop_front();
                    compare_field("changed_slot", want.slot, o_changed_slot);
                    compare_field("slot_value", want.value, o_slot_value);
                    compare_field("mirror_mode", want.mirror, o_mirror_mode);
                    compare_field("irq_pulse", want.pulse, o_irq_pulse);
                    compare_field("irq_enabled", want.enabled, o_irq_enabled);
                    compare_field("irq_count", want.count, o_irq_count);
                end
            end
            if (push && !full) pending_bank_updates.push_back(map_request(i_op, i_addr, i_data));
        end
        o_outstanding <= pending_bank_updates.size();
    end

endmodule

// ----- dv/cartridge_bank_mapper_irq_tb.sv -----
// Testbench top for the cartridge bank mapper: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module cartridge_bank_mapper_irq_tb;

    // Sound registers sit in the write space but must leave the mapper untouched.
    localparam logic [15:0] ADDR_SOUND_SEL  = 16'h9010;
    localparam logic [15:0] ADDR_SOUND_DATA = 16'h9030;
    // Address bits that the decode ignores; fill them with noise.
    localparam logic [15:0] ADDR_DONT_CARE  = 16'h0fcf;

    localparam int PHASES          = 9;
    localparam int REQS_PER_PHASE  = 125;
    localparam int SETTLE_CYCLES   = 12;
    localparam int HOLD_CYCLES     = 80;
    localparam int STALL_LIMIT     = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [8:0]  i_cfg_prg_page_count = cbm_pkg::PAGE_COUNT_RESET;
    logic        push = 1'b0;
    logic        full;
    logic        i_op = cbm_pkg::OP_WRITE;
    logic [15:0] i_addr = 16'h0000;
    logic [7:0]  i_data = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic [3:0]  o_changed_slot;
    logic [7:0]  o_slot_value;
    logic [1:0]  o_mirror_mode;
    logic        o_irq_pulse;
    logic        o_irq_enabled;
    logic [7:0]  o_irq_count;

    int check_errors;
    int results_outstanding;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;
    bit hold_pop = 1'b0;

    always #5 i_clk = ~i_clk;

    cartridge_bank_mapper_irq uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_prg_page_count (i_cfg_prg_page_count),
        .push                 (push),
        .full                 (full),
        .i_op                 (i_op),
        .i_addr               (i_addr),
        .i_data               (i_data),
        .empty                (empty),
        .pop                  (pop),
        .o_changed_slot       (o_changed_slot),
        .o_slot_value         (o_slot_value),
        .o_mirror_mode        (o_mirror_mode),
        .o_irq_pulse          (o_irq_pulse),
        .o_irq_enabled        (o_irq_enabled),
        .o_irq_count          (o_irq_count)
    );

    cartridge_bank_mapper_irq_checker checker_i (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_prg_page_count (i_cfg_prg_page_count),
        .push                 (push),
        .full                 (full),
        .i_op                 (i_op),
        .i_addr               (i_addr),
        .i_data               (i_data),
        .empty                (empty),
        .pop                  (pop),
        .o_changed_slot       (o_changed_slot),
        .o_slot_value         (o_slot_value),
        .o_mirror_mode        (o_mirror_mode),
        .o_irq_pulse          (o_irq_pulse),
        .o_irq_enabled        (o_irq_enabled),
        .o_irq_count          (o_irq_count),
        .o_mismatches         (check_errors),
        .o_outstanding        (results_outstanding)
    );

    // Offer one request, idling first at the current sender rate. Push is left
    // high on return so that back-to-back requests never drop it for a step.
    task automatic send_request(logic op, logic [15:0] addr, logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_op   <= op;
        i_addr <= addr;
        i_data <= data;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic send_write(logic [15:0] addr, logic [7:0] data);
        send_request(cbm_pkg::OP_WRITE, addr, data);
    endtask

    task automatic send_tick();
        send_request(cbm_pkg::OP_TICK, 16'($urandom()), 8'($urandom()));
    endtask

    // Mostly well-formed mapper traffic with noise in the ignored address bits;
    // latch values lean towards small counts so the IRQ actually fires.
    task automatic send_random();
        int          pick;
        logic [15:0] noise;
        logic [15:0] base;
        logic [7:0]  data;
        pick  = $urandom_range(99);
        noise = 16'($urandom()) & ADDR_DONT_CARE;
        data  = 8'($urandom());
        if (pick < 35) begin
            send_tick();
        end else begin
            if (pick < 50) begin
                case ($urandom_range(2))
                    0: base = cbm_pkg::ADDR_PRG0;
                    1: base = cbm_pkg::ADDR_PRG1;
                    default: base = cbm_pkg::ADDR_PRG2;
                endcase
            end else if (pick < 62) begin
                case ($urandom_range(7))
                    0: base = cbm_pkg::ADDR_CHR0;
                    1: base = cbm_pkg::ADDR_CHR1;
                    2: base = cbm_pkg::ADDR_CHR2;
                    3: base = cbm_pkg::ADDR_CHR3;
                    4: base = cbm_pkg::ADDR_CHR4;
                    5: base = cbm_pkg::ADDR_CHR5;
                    6: base = cbm_pkg::ADDR_CHR6;
                    default: base = cbm_pkg::ADDR_CHR7;
                endcase
            end else if (pick < 67) begin
                base = cbm_pkg::ADDR_MIRROR;
            end else if (pick < 74) begin
                base = cbm_pkg::ADDR_IRQ_LAT;
                if ($urandom_range(9) < 7) data = 8'($urandom_range(8'hf0, 8'hff));
            end else if (pick < 80) begin
                base = cbm_pkg::ADDR_IRQ_CTRL;
            end else if (pick < 85) begin
                base = cbm_pkg::ADDR_IRQ_ACK;
            end else if (pick < 90) begin
                base  = $urandom_range(1) ? ADDR_SOUND_SEL : ADDR_SOUND_DATA;
                noise = 16'($urandom()) & 16'h0f0f;
            end else begin
                base  = 16'($urandom());
                noise = 16'h0000;
            end
            send_write(base | noise, data);
        end
    endtask

    // Hold the write until the block takes it, then drop valid.
    task automatic write_page_count(logic [8:0] count);
        i_cfg_valid          <= 1'b1;
        i_cfg_prg_page_count <= count;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drop push and let every expected result drain, then let the pipe settle.
    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (results_outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: pop at the current stall rate; on request hold off for a long
    // stretch so the block backs up and asserts full.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_pop) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_pop = 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: count cycles in which no request, result or register write moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    initial begin
        int         page_counts [PHASES] = '{2, 1, 256, 0, 255, 3, 100, 128, 7};
        int         send_rates  [PHASES] = '{0, 60, 0, 27, 0, 60, 0, 27, 0};
        int         recv_rates  [PHASES] = '{0, 0, 60, 27, 0, 0, 60, 27, 0};
        logic [8:0] count;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, run at the reset page count of 2.
        send_tick();                                   // tick while the counter is off
        send_write(cbm_pkg::ADDR_PRG0, 8'hff);         // reduced modulo the page count
        send_write(cbm_pkg::ADDR_PRG1, 8'h00);
        send_write(cbm_pkg::ADDR_PRG2 | ADDR_DONT_CARE, 8'h80);
        send_write(cbm_pkg::ADDR_CHR0, 8'h00);
        send_write(cbm_pkg::ADDR_CHR1, 8'hff);
        send_write(cbm_pkg::ADDR_CHR2, 8'h55);
        send_write(cbm_pkg::ADDR_CHR3, 8'haa);
        send_write(cbm_pkg::ADDR_CHR4, 8'h01);
        send_write(cbm_pkg::ADDR_CHR5, 8'h80);
        send_write(cbm_pkg::ADDR_CHR6, 8'h7f);
        send_write(cbm_pkg::ADDR_CHR7 | ADDR_DONT_CARE, 8'hfe);
        send_write(cbm_pkg::ADDR_MIRROR, 8'h00);
        send_write(cbm_pkg::ADDR_MIRROR, 8'h03);
        send_write(cbm_pkg::ADDR_MIRROR, 8'hfe);
        send_write(cbm_pkg::ADDR_IRQ_LAT, 8'hfe);      // latch of one
        send_write(cbm_pkg::ADDR_IRQ_CTRL, 8'h03);     // enable, re-enable after acknowledge
        send_tick();                                   // count down to zero
        send_tick();                                   // fire and disable
        send_tick();                                   // disabled again: no change
        send_write(cbm_pkg::ADDR_IRQ_ACK, 8'h00);      // restore enable, reload the counter
        send_tick();
        send_write(ADDR_SOUND_SEL, 8'h12);             // sound registers leave banks alone
        send_write(ADDR_SOUND_DATA, 8'h34);
        send_write(16'h0000, 8'hff);                   // unmapped
        send_write(16'hffff, 8'h00);                   // unmapped

        // Random phases: change the page count while idle, then vary the idling.
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            count = (p == PHASES - 1) ? 9'($urandom_range(1, 256)) : 9'(page_counts[p]);
            write_page_count(count);
            send_idle_pct  = send_rates[p];
            recv_stall_pct = recv_rates[p];
            if (p == 0) hold_pop = 1'b1;
            repeat (REQS_PER_PHASE) send_random();
        end

        drain_results();
        if (check_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/cbm_pkg.sv
rtl/cbm_front.sv
rtl/cbm_cmd_fifo.sv
rtl/cbm_back.sv
rtl/cartridge_bank_mapper_irq.sv
dv/cartridge_bank_mapper_irq_checker.sv
dv/cartridge_bank_mapper_irq_tb.sv
